>>> rtl/core/aapb_pkg.sv
// Shared types and constants for the adaptive audio playout buffer.
// Used by the ring RAM wrapper users and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package aapb_pkg;

   localparam int FRAME_SAMPLES = 64;
   localparam int RING_DEPTH    = 3 * FRAME_SAMPLES;
   localparam int RING_HALF     = RING_DEPTH / 2;
   localparam int RING_AW       = $clog2(RING_DEPTH);

   localparam int SAMPLE_W = 16;
   localparam int PERIOD_W = 24;
   localparam int STEP_W   = 16;
   localparam int TARGET_W = 8;
   localparam int FILL_W   = 10;
   localparam int PEND_W   = 8;

   localparam logic [PERIOD_W-1:0] BASE_PERIOD_RESET = PERIOD_W'(1000);
   localparam logic [STEP_W-1:0]   PERIOD_STEP_RESET = '0;
   localparam logic [TARGET_W-1:0] TARGET_FILL_RESET = TARGET_W'(64);

   typedef enum logic [2:0] {
      OP_WRITE_SAMPLE = 3'd0,
      OP_PACKET_END   = 3'd1,
      OP_SAMPLE_TICK  = 3'd2,
      OP_RESTART      = 3'd3,
      OP_SET_MUTE     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      REG_BASE_PERIOD = 2'd0,
      REG_PERIOD_STEP = 2'd1,
      REG_TARGET_FILL = 2'd2
   } reg_index_type;

   // Result item; the last member sits in the lowest bits.
   typedef struct packed {
      logic                       playing;
      logic [PERIOD_W-1:0]        next_period;
      logic signed [SAMPLE_W-1:0] dac_sample;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> rtl/core/adaptive_audio_playout_buffer_core.sv
// Top level of the adaptive audio playout buffer: control registers, rate
// adaptation, APB-style register port and a two-entry result buffer.
// Depends on aapb_pkg and the ring RAM aapb_ram.
//
// Channel | Direction | Handshake       | Payload
// req_    | in        | tvalid/tready   | tuser = op, tdata = sample
// rsp_    | out       | tvalid/tready   | tdata = dac_sample, next_period, playing
// csr_    | in        | psel/penable    | 32-bit registers at byte offsets 0, 4, 8
//
// One item is accepted per cycle while req_tready is high; each tick yields a result.
// A tick reads the ring RAM through its one read port; the word fetched lands in
// the RAM's read register and is sent on the following tick.
// Reset is synchronous; the ring is not cleared.
// Results go to a two-entry buffer; req_tready drops only while both entries hold.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_audio_playout_buffer_core
   import aapb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [15:0] sample
   input  wire logic [2:0]  req_tuser,  // [2:0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // [15:0] dac_sample, [39:16] next_period,
                                        // [40] playing, [47:41] zero
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers.
   logic [PERIOD_W-1:0] base_period_ff;
   logic [STEP_W-1:0]   period_step_ff;
   logic [TARGET_W-1:0] target_fill_ff;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_period_ff <= BASE_PERIOD_RESET;
         period_step_ff <= PERIOD_STEP_RESET;
         target_fill_ff <= TARGET_FILL_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_BASE_PERIOD: base_period_ff <= csr_pwdata[PERIOD_W-1:0];
            REG_PERIOD_STEP: period_step_ff <= csr_pwdata[STEP_W-1:0];
            REG_TARGET_FILL: target_fill_ff <= csr_pwdata[TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BASE_PERIOD: csr_prdata = {{(32-PERIOD_W){1'b0}}, base_period_ff};
         REG_PERIOD_STEP: csr_prdata = {{(32-STEP_W){1'b0}}, period_step_ff};
         REG_TARGET_FILL: csr_prdata = {{(32-TARGET_W){1'b0}}, target_fill_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Playout state.
   logic [RING_AW-1:0]  write_index_ff, write_index_in;
   logic [RING_AW-1:0]  read_index_ff, read_index_in;
   logic [FILL_W-1:0]   fill_count_ff, fill_count_in;
   logic [PEND_W-1:0]   pending_count_ff, pending_count_in;
   logic                play_enable_ff, play_enable_in;
   logic [PERIOD_W-1:0] held_period_ff, held_period_in;
   logic                mute_flag_ff, mute_flag_in;
   // The held sample is the RAM read register when this is set, else zero.
   logic                held_from_ram_ff, held_from_ram_in;

   logic                in_accept;
   op_type              op;
   logic                ram_wr_en, ram_rd_en;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic                tick;
   rsp_item_type        tick_item;

   logic [PERIOD_W-1:0] adapted_period;
   logic [PERIOD_W-1:0] period_minus;
   logic [PERIOD_W:0]   period_plus;
   logic [FILL_W:0]     fill_sum;

   assign in_accept = req_tvalid & req_tready;
   assign op        = op_type'(req_tuser);

   always_comb begin
      period_minus = ({{(PERIOD_W-STEP_W){1'b0}}, period_step_ff} >= base_period_ff) ? '0 :
                     base_period_ff - {{(PERIOD_W-STEP_W){1'b0}}, period_step_ff};
      period_plus  = {1'b0, base_period_ff} + {{(PERIOD_W+1-STEP_W){1'b0}}, period_step_ff};
      // The fill taken here is the one before this packet is committed.
      priority if (fill_count_ff > {{(FILL_W-TARGET_W){1'b0}}, target_fill_ff}) begin
         adapted_period = period_minus;
      end else if (fill_count_ff < {{(FILL_W-TARGET_W){1'b0}}, target_fill_ff}) begin
         adapted_period = period_plus[PERIOD_W] ? '1 : period_plus[PERIOD_W-1:0];
      end else begin
         adapted_period = base_period_ff;
      end
   end

   assign fill_sum = {1'b0, fill_count_ff} + {{(FILL_W+1-PEND_W){1'b0}}, pending_count_ff};

   always_comb begin
      write_index_in   = write_index_ff;
      read_index_in    = read_index_ff;
      fill_count_in    = fill_count_ff;
      pending_count_in = pending_count_ff;
      play_enable_in   = play_enable_ff;
      held_period_in   = held_period_ff;
      mute_flag_in     = mute_flag_ff;
      held_from_ram_in = held_from_ram_ff;
      ram_wr_en        = 1'b0;
      ram_rd_en        = 1'b0;
      tick             = 1'b0;
      if (in_accept) begin
         unique case (op)
            OP_WRITE_SAMPLE: begin
               ram_wr_en      = 1'b1;
               write_index_in = (write_index_ff == RING_AW'(RING_DEPTH - 1)) ? '0 :
                                write_index_ff + 1'b1;
               if (pending_count_ff != '1) begin
                  pending_count_in = pending_count_ff + 1'b1;
               end
            end
            OP_PACKET_END: begin
               if (play_enable_ff) begin
                  held_period_in = adapted_period;
               end else if (write_index_ff >= RING_AW'(RING_HALF)) begin
                  read_index_in  = '0;
                  play_enable_in = 1'b1;
               end
               fill_count_in    = fill_sum[FILL_W] ? '1 : fill_sum[FILL_W-1:0];
               pending_count_in = '0;
            end
            OP_SAMPLE_TICK: begin
               tick = 1'b1;
               if (play_enable_ff && fill_count_ff != '0) begin
                  ram_rd_en        = 1'b1;
                  read_index_in    = (read_index_ff == RING_AW'(RING_DEPTH - 1)) ? '0 :
                                     read_index_ff + 1'b1;
                  fill_count_in    = fill_count_ff - 1'b1;
                  held_from_ram_in = ~mute_flag_ff;
               end else begin
                  play_enable_in   = 1'b0;
                  held_period_in   = base_period_ff;
                  held_from_ram_in = 1'b0;
               end
            end
            OP_RESTART: begin
               write_index_in   = '0;
               fill_count_in    = '0;
               pending_count_in = '0;
            end
            OP_SET_MUTE: begin
               mute_flag_in = req_tdata[0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff   <= '0;
         read_index_ff    <= '0;
         fill_count_ff    <= '0;
         pending_count_ff <= '0;
         play_enable_ff   <= 1'b0;
         held_period_ff   <= BASE_PERIOD_RESET;
         mute_flag_ff     <= 1'b0;
         held_from_ram_ff <= 1'b0;
      end else begin
         write_index_ff   <= write_index_in;
         read_index_ff    <= read_index_in;
         fill_count_ff    <= fill_count_in;
         pending_count_ff <= pending_count_in;
         play_enable_ff   <= play_enable_in;
         held_period_ff   <= held_period_in;
         mute_flag_ff     <= mute_flag_in;
         held_from_ram_ff <= held_from_ram_in;
      end
   end

   aapb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_index_ff),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (read_index_ff),
      .rd_data (ram_rd_data)
   );

   // The sample sent now is the one fetched on the previous tick.
   assign tick_item.dac_sample  = held_from_ram_ff ? ram_rd_data : '0;
   assign tick_item.next_period = held_period_in;
   assign tick_item.playing     = play_enable_in;

   // Two-entry result buffer: head register plus skid register.
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_data_ff, out_data_in;
   rsp_item_type skid_data_ff, skid_data_in;
   logic         pop;

   assign pop        = out_valid_ff & rsp_tready;
   assign req_tready = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_data_in  = tick_item;
            skid_valid_in = tick;
         end else begin
            out_data_in  = tick_item;
            out_valid_in = tick;
         end
      end else if (tick) begin
         skid_data_in  = tick_item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(48 - $bits(rsp_item_type)){1'b0}}, out_data_ff};

   assert property (@(posedge clock) disable iff (reset)
      write_index_ff < RING_AW'(RING_DEPTH) && read_index_ff < RING_AW'(RING_DEPTH))
      else $error("ring index out of range");

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while head entry is empty");

   assert property (@(posedge clock) disable iff (reset)
      tick |=> rsp_tvalid)
      else $error("sample tick produced no result");

   assert property (@(posedge clock) disable iff (reset)
      $rose(play_enable_ff) |-> read_index_ff == '0)
      else $error("playout started with nonzero read index");

   assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> !ram_wr_en)
      else $error("ring read and write in the same cycle");

endmodule

`default_nettype wire

>>> rtl/core/aapb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// The read register holds its value until the next read is enabled.
`timescale 1ns / 1ps
`default_nettype none

module aapb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> dv/tb_adaptive_audio_playout_buffer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_audio_playout_buffer_core: streams sample writes,
// packet ends and sample ticks, predicts every tick result and compares it field by field.
// Depends on aapb_pkg and the core; register settings change only while the block is idle.

module tb_adaptive_audio_playout_buffer_core;
   import aapb_pkg::*;

   localparam int STREAM_ITEMS  = 450;
   localparam int CFG_SPACING   = 70;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int FILL_MAX      = 1023;
   localparam int PEND_MAX      = 255;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

   class playout_scoreboard;
      logic [SAMPLE_W-1:0] ring [RING_DEPTH];
      bit                  written [RING_DEPTH];
      int unsigned         wr_idx, rd_idx, fill, pend;
      bit                  playing, muted;
      logic [PERIOD_W-1:0] held_period, base_period;
      logic [STEP_W-1:0]   period_step;
      logic [TARGET_W-1:0] target_fill;
      logic [SAMPLE_W-1:0] held_sample;
      rsp_item_type        expected_q[$];
      int                  errors, checked;

      function new();
         foreach (ring[i]) begin
            ring[i] = '0;
            written[i] = 1'b0;
         end
         wr_idx = 0;
         rd_idx = 0;
         fill = 0;
         pend = 0;
         playing = 1'b0;
         muted = 1'b0;
         held_sample = '0;
         base_period = BASE_PERIOD_RESET;
         period_step = PERIOD_STEP_RESET;
         target_fill = TARGET_FILL_RESET;
         held_period = BASE_PERIOD_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_BASE_PERIOD: base_period = value[PERIOD_W-1:0];
            REG_PERIOD_STEP: period_step = value[STEP_W-1:0];
            REG_TARGET_FILL: target_fill = value[TARGET_W-1:0];
            default: ;
         endcase
      endfunction

      // A tick must never fetch a ring entry that has not been written since power-up.
      function bit tick_hits_unwritten();
         return playing && fill != 0 && !written[rd_idx];
      endfunction

      function logic [PERIOD_W-1:0] adapted_period();
         logic [PERIOD_W:0] sum;
         sum = {1'b0, base_period} + period_step;
         if (fill > target_fill)
            return (period_step >= base_period) ? '0 : base_period - period_step;
         if (fill < target_fill)
            return sum[PERIOD_W] ? PERIOD_MAX : sum[PERIOD_W-1:0];
         return base_period;
      endfunction

      function void note_input(logic [2:0] op, logic [SAMPLE_W-1:0] smp);
         rsp_item_type item;
         case (op)
            OP_WRITE_SAMPLE: begin
               ring[wr_idx] = smp;
               written[wr_idx] = 1'b1;
               wr_idx = (wr_idx + 1) % RING_DEPTH;
               if (pend < PEND_MAX)
                  pend++;
            end
            OP_PACKET_END: begin
               // The rate decision uses the fill level from before this commit.
               if (playing) begin
                  held_period = adapted_period();
               end else if (wr_idx >= RING_HALF) begin
                  rd_idx = 0;
                  playing = 1'b1;
               end
               fill = (fill + pend > FILL_MAX) ? FILL_MAX : fill + pend;
               pend = 0;
            end
            OP_SAMPLE_TICK: begin
               item.dac_sample = held_sample;
               if (playing && fill != 0) begin
                  held_sample = muted ? '0 : ring[rd_idx];
                  rd_idx = (rd_idx + 1) % RING_DEPTH;
                  fill--;
               end else begin
                  playing = 1'b0;
                  held_period = base_period;
                  held_sample = '0;
               end
               item.next_period = held_period;
               item.playing = playing;
               expected_q.push_back(item);
            end
            OP_RESTART: begin
               wr_idx = 0;
               fill = 0;
               pend = 0;
            end
            OP_SET_MUTE: muted = smp[0];
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 50)
            $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_result(logic [47:0] data);
         rsp_item_type got, want;
         got = data[40:0];
         checked++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with no sample tick waiting", data));
            return;
         end
         want = expected_q.pop_front();
         if (got.dac_sample !== want.dac_sample)
            report_mismatch($sformatf("dac_sample %0d, expected %0d",
                                      got.dac_sample, want.dac_sample));
         if (got.next_period !== want.next_period)
            report_mismatch($sformatf("next_period %0d, expected %0d",
                                      got.next_period, want.next_period));
         if (got.playing !== want.playing)
            report_mismatch($sformatf("playing %b, expected %b", got.playing, want.playing));
         if (data[47:41] !== '0)
            report_mismatch($sformatf("padding bits %b are not zero", data[47:41]));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // [15:0] sample
   logic [2:0]  req_tuser = '0;  // [2:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [47:0] rsp_tdata;       // [15:0] dac_sample, [39:16] next_period, [40] playing
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bit                steady = 1'b0;
   int                items_sent = 0;
   int                settings = 0;
   int                idle_cycles = 0;
   playout_scoreboard sb;

   adaptive_audio_playout_buffer_core dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 7);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(19))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(logic [2:0] op, logic [15:0] smp);
      while (!steady && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= smp;
      do @(posedge clock); while (!req_tready);
      sb.note_input(op, smp);
      if (op <= OP_SET_MUTE)
         items_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick();
      if (sb.tick_hits_unwritten())
         send_item(OP_WRITE_SAMPLE, rand_sample());
      else
         send_item(OP_SAMPLE_TICK, 16'($urandom));
   endtask

   // Writes and ticks are shuffled together, then the packet is closed.
   task automatic stream_packet(int n_writes, int n_ticks);
      int w, t;
      w = 0;
      t = 0;
      while (w < n_writes || t < n_ticks) begin
         if (t >= n_ticks || (w < n_writes &&
             $urandom_range(n_writes + n_ticks - w - t - 1) < n_writes - w)) begin
            send_item(OP_WRITE_SAMPLE, rand_sample());
            w++;
         end else begin
            send_tick();
            t++;
         end
      end
      send_item(OP_PACKET_END, 16'($urandom));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_config(logic [23:0] base, logic [15:0] step, logic [7:0] target);
      csr_write(REG_BASE_PERIOD, 32'(base));
      csr_write(REG_PERIOD_STEP, 32'(step));
      csr_write(REG_TARGET_FILL, 32'(target));
      settings++;
   endtask

   task automatic choose_config(int pick);
      case (pick)
         0: apply_config(24'd1, 16'hFFFF, 8'd0);
         1: apply_config(24'hFF0000, 16'hFFFF, 8'd192);
         2: apply_config(24'd1, 16'd0, 8'd192);
         3: apply_config(24'($urandom_range(1, 24'hFF0000)),
                         16'($urandom_range(0, 16'hFFFF)),
                         8'($urandom_range(0, 192)));
         default: apply_config(24'($urandom_range(500, 2000)), 16'($urandom_range(1, 50)),
                               8'($urandom_range(32, 128)));
      endcase
   endtask

   initial begin
      int cfg_order[5] = '{0, 4, 1, 3, 2};
      int cfg_count, next_cfg, n, r, r2;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      choose_config(4);

      // Directed: ticks while stopped, ignored codes, mute bit, sample extremes,
      // a packet end below the half-ring mark and a restart.
      send_tick();
      send_item(OP_FIRST_UNUSED, 16'hFFFF);
      send_item(OP_FIRST_UNUSED + 3'd1, 16'h0000);
      send_item(OP_LAST_UNUSED, 16'hAAAA);
      send_item(OP_SET_MUTE, 16'hFFFF);
      send_item(OP_SET_MUTE, 16'hFFFE);
      send_item(OP_WRITE_SAMPLE, 16'h7FFF);
      send_item(OP_WRITE_SAMPLE, 16'h8000);
      send_item(OP_WRITE_SAMPLE, 16'h0000);
      send_item(OP_WRITE_SAMPLE, 16'hFFFF);
      send_item(OP_WRITE_SAMPLE, 16'h5555);
      send_item(OP_WRITE_SAMPLE, 16'hAAAA);
      send_item(OP_PACKET_END, 16'h0000);
      send_tick();
      send_item(OP_RESTART, 16'hFFFF);
      send_item(OP_PACKET_END, 16'hFFFF);
      send_tick();

      cfg_count = 0;
      next_cfg = items_sent;
      while (items_sent < STREAM_ITEMS) begin
         if (items_sent >= next_cfg) begin
            settle();
            choose_config(cfg_count < 5 ? cfg_order[cfg_count] : $urandom_range(3, 4));
            cfg_count++;
            next_cfg += CFG_SPACING;
         end
         steady = (items_sent >= 150 && items_sent < 300);
         r = $urandom_range(99);
         if (r < 3) begin
            send_item(OP_RESTART, 16'($urandom));
         end else if (r < 8) begin
            send_item(OP_SET_MUTE, {15'($urandom), 1'($urandom_range(99) < 30)});
         end else if (r < 11) begin
            send_item(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), 16'($urandom));
         end else if (r < 15) begin
            // Drain the ring with at most 150 ticks; playout stops on an empty buffer unless the fill is above 149.
            n = (sb.fill + 2 > 150) ? 150 : sb.fill + 2;
            repeat (n) send_tick();
         end else if (r < 19) begin
            repeat ($urandom_range(3)) send_item(OP_WRITE_SAMPLE, rand_sample());
            send_item(OP_PACKET_END, 16'($urandom));
         end else begin
            n = $urandom_range(16, 80);
            r2 = $urandom_range(99);
            stream_packet(n, r2 < 15 ? 0 : r2 < 30 ? 2 * n : n - 8 + $urandom_range(16));
         end
      end
      steady = 1'b0;

      // Five packets with no ticks saturate the pending count and then the fill count;
      // the following packet ends adapt the period against a full buffer.
      settle();
      apply_config(24'd1000, 16'd40, 8'd192);
      for (int p = 0; p < 5; p++) begin
         repeat (p == 0 ? 260 : 200) send_item(OP_WRITE_SAMPLE, rand_sample());
         send_item(OP_PACKET_END, 16'($urandom));
      end
      repeat (2) stream_packet(10, 4);
      repeat (6) send_tick();

      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d items under %0d register settings, covering playout start, underrun,",
               items_sent, settings);
      $display("mute, restart and counter saturation; %0d results checked, %0d mismatches.",
               sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
